[src/bdh_pkg.sv]
// bdh_pkg: shared types and constants for the button debounce / hold timer.
// Operation codes, register indexes, the millisecond-to-second reciprocal and
// the config / state structs used by the step logic and the top level.
package bdh_pkg;

   // Operation codes carried by an item
   localparam logic [1:0] OP_SAMPLE       = 2'd0;
   localparam logic [1:0] OP_TAKE_PRESS   = 2'd1;
   localparam logic [1:0] OP_TAKE_RELEASE = 2'd2;
   localparam logic [1:0] OP_RESTART      = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] REG_PIN_MASK         = 2'd0;
   localparam logic [1:0] REG_ACTIVE_HIGH      = 2'd1;
   localparam logic [1:0] REG_TOGGLE_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_INITIAL_ACTIVE   = 2'd3;

   // Register reset values
   localparam logic [7:0] PIN_MASK_RST         = 8'd1;
   localparam logic [7:0] TOGGLE_THRESHOLD_RST = 8'd4;

   // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38, exact for all 32-bit x
   localparam int         RECIP_SHIFT = 38;
   localparam logic [28:0] MS_RECIP   = 29'd274877907;

   localparam logic [15:0] HOLD_MAX = 16'hFFFF;
   localparam logic [15:0] HOLD_MIN = 16'd1;

   typedef struct packed {
      logic [7:0] pin_mask;
      logic       active_high;
      logic [7:0] toggle_threshold;
      logic       initial_active;
   } cfg_type;

   typedef struct packed {
      logic        debounced_active;
      logic [7:0]  disagree_count;
      logic [31:0] press_start_time;
      logic [15:0] held_value;
      logic [15:0] release_held_value;
      logic        press_pending;
      logic        release_pending;
   } state_type;

   typedef struct packed {
      logic        pressed_level;
      logic        active;
      logic [15:0] held_seconds;
      logic        event_flag;
      logic [15:0] released_held_seconds;
   } result_type;

endpackage

[src/bdh_hold_calc.sv]
// bdh_hold_calc: elapsed whole seconds since the press start time.
// Modulo-2^32 difference, then divide by 1000 via reciprocal multiply.
// Depends on bdh_pkg.
module bdh_hold_calc
   import bdh_pkg::*;
(
   input  logic [31:0] now_ms,
   input  logic [31:0] start_ms,
   output logic [15:0] secs
);

   logic [31:0] elapsed;
   logic [60:0] product;

   // wrap-safe elapsed time
   assign elapsed = now_ms - start_ms;

   // one 32 x 29 multiply, quotient sits above the shift point
   assign product = 61'(elapsed) * 61'(MS_RECIP);
   assign secs    = product[RECIP_SHIFT +: 16];

endmodule

[src/bdh_step.sv]
// bdh_step: next-state and result logic for one item.
// Debounce counter, toggle, event latching, hold saturation and restart.
// Depends on bdh_pkg; takes elapsed seconds from bdh_hold_calc.
module bdh_step
   import bdh_pkg::*;
(
   input  cfg_type     cfg,
   input  state_type   cur,
   input  logic [1:0]  opcode,
   input  logic [7:0]  pin_levels,
   input  logic [31:0] time_ms,
   input  logic [15:0] secs,
   output state_type   nxt,
   output result_type  res
);

   logic       all_high;
   logic       level_match;
   logic [7:0] count_upd;
   logic       toggle;
   logic [15:0] held_upd;

   // raw pin decode
   assign all_high    = ((~pin_levels) & cfg.pin_mask) == 8'd0;
   assign level_match = (all_high == cfg.active_high);

   // count samples disagreeing with the debounced state
   always_comb begin
      if (level_match) begin
         count_upd = cur.debounced_active ? 8'd0 : cur.disagree_count + 8'd1;
      end else begin
         count_upd = cur.debounced_active ? cur.disagree_count + 8'd1 : 8'd0;
      end
   end

   assign toggle = (count_upd >= cfg.toggle_threshold);

   // hold time while staying active, sticky saturation on wrap
   always_comb begin
      if (secs < cur.held_value) begin
         held_upd = HOLD_MAX;
      end else if (secs == 16'd0) begin
         held_upd = HOLD_MIN;
      end else begin
         held_upd = secs;
      end
   end

   always_comb begin
      nxt = cur;
      res = '0;
      unique case (opcode)
         OP_SAMPLE: begin
            res.pressed_level = level_match;
            if (toggle) begin
               nxt.disagree_count   = 8'd0;
               nxt.debounced_active = ~cur.debounced_active;
               if (!cur.debounced_active) begin
                  // press: elapsed is zero, so the held time reads one
                  nxt.press_start_time = time_ms;
                  nxt.press_pending    = 1'b1;
                  nxt.held_value       = HOLD_MIN;
               end else begin
                  nxt.release_pending    = 1'b1;
                  nxt.release_held_value = cur.held_value;
                  nxt.press_start_time   = 32'd0;
                  nxt.held_value         = 16'd0;
               end
            end else begin
               nxt.disagree_count = count_upd;
               nxt.held_value     = cur.debounced_active ? held_upd : 16'd0;
            end
         end
         OP_TAKE_PRESS: begin
            res.event_flag    = cur.press_pending;
            nxt.press_pending = 1'b0;
         end
         OP_TAKE_RELEASE: begin
            res.event_flag      = cur.release_pending;
            nxt.release_pending = 1'b0;
         end
         OP_RESTART: begin
            nxt.press_start_time   = time_ms;
            nxt.held_value         = 16'd0;
            nxt.release_held_value = 16'd0;
            nxt.press_pending      = 1'b0;
            nxt.release_pending    = 1'b0;
            nxt.disagree_count     = 8'd0;
            nxt.debounced_active   = cfg.initial_active;
         end
         default: begin
            nxt = cur;
         end
      endcase
      res.active                = nxt.debounced_active;
      res.held_seconds          = nxt.held_value;
      res.released_held_seconds = nxt.release_held_value;
   end

endmodule

[src/button_debounce_hold_timer_core.sv]
// Button debouncer with hold timer: input register, combinational state update, result register.
// An accepted item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle while no result is stalled; the state update plus the 32 x 29
// reciprocal multiply of the held-seconds path sit in the single stage between the two registers.
// Reset (synchronous, active high): registers to their defaults, state cleared, pipeline empty.
// Depends on bdh_pkg, bdh_hold_calc and bdh_step.
module button_debounce_hold_timer_core
   import bdh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_pin_levels,
   input  logic [31:0] req_time_ms,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pressed_level,
   output logic        rsp_active,
   output logic [15:0] rsp_held_seconds,
   output logic        rsp_event_flag,
   output logic [15:0] rsp_released_held_seconds,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   state_type   state_ff;
   state_type   state_nxt;
   result_type  res_comb;
   result_type  res_ff;

   logic        in_valid_ff;
   logic [1:0]  in_opcode_ff;
   logic [7:0]  in_pins_ff;
   logic [31:0] in_time_ff;
   logic        rsp_valid_ff;
   logic        advance;
   logic [15:0] secs;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PIN_MASK:         cfg_in.pin_mask         = csr_wdata;
            REG_ACTIVE_HIGH:      cfg_in.active_high      = csr_wdata[0];
            REG_TOGGLE_THRESHOLD: cfg_in.toggle_threshold = csr_wdata;
            REG_INITIAL_ACTIVE:   cfg_in.initial_active   = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_mask         <= PIN_MASK_RST;
         cfg_ff.active_high      <= 1'b0;
         cfg_ff.toggle_threshold <= TOGGLE_THRESHOLD_RST;
         cfg_ff.initial_active   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the stage moves unless a waiting result is stalled
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_opcode_ff <= req_opcode;
         in_pins_ff   <= req_pin_levels;
         in_time_ff   <= req_time_ms;
      end
   end

   // held-seconds arithmetic and state step
   bdh_hold_calc u_hold (
      .now_ms   (in_time_ff),
      .start_ms (state_ff.press_start_time),
      .secs     (secs)
   );

   bdh_step u_step (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .opcode     (in_opcode_ff),
      .pin_levels (in_pins_ff),
      .time_ms    (in_time_ff),
      .secs       (secs),
      .nxt        (state_nxt),
      .res        (res_comb)
   );

   // block state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_pressed_level         = res_ff.pressed_level;
   assign rsp_active                = res_ff.active;
   assign rsp_held_seconds          = res_ff.held_seconds;
   assign rsp_event_flag            = res_ff.event_flag;
   assign rsp_released_held_seconds = res_ff.released_held_seconds;

endmodule

[src/bdh_checker.sv]
// bdh_checker: port-level assertions for button_debounce_hold_timer_core.
// Bound to the top level at the end of this file; depends on nothing else.
module bdh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_active,
   input logic [15:0] rsp_held_seconds,
   input logic [15:0] rsp_released_held_seconds
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_held_seconds)
         && $stable(rsp_released_held_seconds) && $stable(rsp_active))
      else $error("stalled result changed");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // released button reports no held time
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_held_seconds == 16'd0)
      else $error("held time nonzero while released");

endmodule

bind button_debounce_hold_timer_core bdh_checker u_bdh_checker (
   .clock                     (clock),
   .reset                     (reset),
   .req_stall                 (req_stall),
   .rsp_valid                 (rsp_valid),
   .rsp_stall                 (rsp_stall),
   .rsp_active                (rsp_active),
   .rsp_held_seconds          (rsp_held_seconds),
   .rsp_released_held_seconds (rsp_released_held_seconds)
);

[verif/button_debounce_hold_timer_core_tb.sv]
// Self-checking testbench for button_debounce_hold_timer_core: a directed table of items
// and register writes, then randomised phases, checked against an in-bench predictor or typed-in expectations.
// Depends on bdh_pkg and the button_debounce_hold_timer_core RTL.
module button_debounce_hold_timer_core_tb;
   import bdh_pkg::*;

   localparam logic [31:0] MS_PER_S    = 32'd1000;
   localparam int          GAP_MAX     = 17;
   localparam int          PHASE_ITEMS = 120;
   localparam int          N_PHASES    = 8;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]  op;
      logic [7:0]  pins;
      logic [31:0] tms;
      logic        known;
      result_type  res;
      logic [1:0]  idx;
      logic [7:0]  wdata;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_opcode;
   logic [7:0]  req_pin_levels;
   logic [31:0] req_time_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_pressed_level;
   logic        rsp_active;
   logic [15:0] rsp_held_seconds;
   logic        rsp_event_flag;
   logic [15:0] rsp_released_held_seconds;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   // predictor copy of registers and state
   cfg_type     dbc_cfg;
   state_type   dbc_st;
   result_type  pending_results[$];
   stim_row_type directed_rows[$];

   // typed-in expectation travelling with the item on the bus
   logic        cur_known;
   result_type  cur_result;

   int          mismatch_count;
   int          rsp_hold;
   bit          send_quiet;
   bit          recv_quiet;
   logic [31:0] clock_ms;

   button_debounce_hold_timer_core DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_opcode               (req_opcode),
      .req_pin_levels           (req_pin_levels),
      .req_time_ms              (req_time_ms),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_pressed_level        (rsp_pressed_level),
      .rsp_active               (rsp_active),
      .rsp_held_seconds         (rsp_held_seconds),
      .rsp_event_flag           (rsp_event_flag),
      .rsp_released_held_seconds(rsp_released_held_seconds),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Debounce and hold-time prediction for one item; updates dbc_st
   function automatic result_type advance_button(logic [1:0] op, logic [7:0] pins,
                                                 logic [31:0] now);
      result_type  r;
      logic        all_high;
      logic [31:0] elapsed;
      logic [15:0] secs;
      r = '0;
      unique case (op)
         OP_SAMPLE: begin
            all_high = ((~pins & dbc_cfg.pin_mask) == 8'd0);
            if (all_high == dbc_cfg.active_high) begin
               r.pressed_level = 1'b1;
               dbc_st.disagree_count = dbc_st.debounced_active ? 8'd0
                                                               : dbc_st.disagree_count + 8'd1;
            end else begin
               dbc_st.disagree_count = dbc_st.debounced_active ? dbc_st.disagree_count + 8'd1
                                                               : 8'd0;
            end
            // toggle the debounced state
            if (dbc_st.disagree_count >= dbc_cfg.toggle_threshold) begin
               dbc_st.debounced_active = ~dbc_st.debounced_active;
               if (dbc_st.debounced_active) begin
                  dbc_st.press_start_time = now;
                  dbc_st.press_pending    = 1'b1;
               end else begin
                  dbc_st.release_pending    = 1'b1;
                  dbc_st.release_held_value = dbc_st.held_value;
                  dbc_st.press_start_time   = '0;
                  dbc_st.held_value         = '0;
               end
               dbc_st.disagree_count = 8'd0;
            end
            // held seconds: floor at 1, sticks at max once the wrapped value drops
            if (!dbc_st.debounced_active) begin
               dbc_st.held_value = '0;
            end else begin
               elapsed = now - dbc_st.press_start_time;
               secs    = 16'(elapsed / MS_PER_S);
               if (secs < dbc_st.held_value)
                  dbc_st.held_value = HOLD_MAX;
               else if (secs == 16'd0)
                  dbc_st.held_value = HOLD_MIN;
               else
                  dbc_st.held_value = secs;
            end
         end
         OP_TAKE_PRESS: begin
            r.event_flag         = dbc_st.press_pending;
            dbc_st.press_pending = 1'b0;
         end
         OP_TAKE_RELEASE: begin
            r.event_flag           = dbc_st.release_pending;
            dbc_st.release_pending = 1'b0;
         end
         OP_RESTART: begin
            dbc_st.press_start_time   = now;
            dbc_st.held_value         = '0;
            dbc_st.release_held_value = '0;
            dbc_st.press_pending      = 1'b0;
            dbc_st.release_pending    = 1'b0;
            dbc_st.disagree_count     = 8'd0;
            dbc_st.debounced_active   = dbc_cfg.initial_active;
         end
      endcase
      r.active                = dbc_st.debounced_active;
      r.held_seconds          = dbc_st.held_value;
      r.released_held_seconds = dbc_st.release_held_value;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Monitor: register writes, accepted items and results, all seen at the rising edge
   always @(posedge clock) begin : watch
      result_type predicted;
      result_type got;
      result_type want;
      if (reset) begin
         dbc_cfg = '{pin_mask: PIN_MASK_RST, active_high: 1'b0,
                     toggle_threshold: TOGGLE_THRESHOLD_RST, initial_active: 1'b0};
         dbc_st  = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_PIN_MASK:         dbc_cfg.pin_mask         = csr_wdata;
               REG_ACTIVE_HIGH:      dbc_cfg.active_high      = csr_wdata[0];
               REG_TOGGLE_THRESHOLD: dbc_cfg.toggle_threshold = csr_wdata;
               REG_INITIAL_ACTIVE:   dbc_cfg.initial_active   = csr_wdata[0];
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = advance_button(req_opcode, req_pin_levels, req_time_ms);
            pending_results.push_back(cur_known ? cur_result : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            got.pressed_level         = rsp_pressed_level;
            got.active                = rsp_active;
            got.held_seconds          = rsp_held_seconds;
            got.event_flag            = rsp_event_flag;
            got.released_held_seconds = rsp_released_held_seconds;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 16'd0, 16'd0);
            end else begin
               want = pending_results.pop_front();
               if (got.pressed_level !== want.pressed_level)
                  report_mismatch("pressed_level", {15'd0, got.pressed_level},
                                  {15'd0, want.pressed_level});
               if (got.active !== want.active)
                  report_mismatch("active", {15'd0, got.active}, {15'd0, want.active});
               if (got.held_seconds !== want.held_seconds)
                  report_mismatch("held_seconds", got.held_seconds, want.held_seconds);
               if (got.event_flag !== want.event_flag)
                  report_mismatch("event_flag", {15'd0, got.event_flag},
                                  {15'd0, want.event_flag});
               if (got.released_held_seconds !== want.released_held_seconds)
                  report_mismatch("released_held_seconds", got.released_held_seconds,
                                  want.released_held_seconds);
            end
            // stall before the next result
            if ($urandom_range(0, 39) == 0)
               recv_quiet = !recv_quiet;
            rsp_hold = recv_quiet ? 0 : $urandom_range(0, GAP_MAX);
         end
      end
   end

   // Receiver back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_stall = 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   function automatic void add_item(logic [1:0] op, logic [7:0] pins, logic [31:0] tms);
      stim_row_type row;
      row = '{kind: ROW_ITEM, op: op, pins: pins, tms: tms, known: 1'b0, res: '0,
              idx: '0, wdata: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(logic [1:0] op, logic [7:0] pins, logic [31:0] tms,
                                     logic lvl, logic act, logic [15:0] held);
      stim_row_type row;
      row = '{kind: ROW_ITEM, op: op, pins: pins, tms: tms, known: 1'b1,
              res: '{lvl, act, held, 1'b0, 16'd0}, idx: '0, wdata: '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [1:0] idx, logic [7:0] wdata);
      stim_row_type row;
      row = '{kind: ROW_WRITE, op: '0, pins: '0, tms: '0, known: 1'b0, res: '0,
              idx: idx, wdata: wdata};
      directed_rows.push_back(row);
   endfunction

   // Pin byte whose masked bits read as pressed (want = 1) or released
   function automatic logic [7:0] pins_for(bit want);
      logic [7:0] p;
      int         b;
      p = 8'($urandom);
      do b = $urandom_range(0, 7); while (!dbc_cfg.pin_mask[b]);
      if ((want ? dbc_cfg.active_high : !dbc_cfg.active_high) == 1'b1)
         p = p | dbc_cfg.pin_mask;
      else
         p[b] = 1'b0;
      return p;
   endfunction

   // Mostly small steps; now and then jumps large enough to wrap the seconds count
   function automatic void tick_ms();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 90)
         clock_ms = clock_ms + $urandom_range(0, 3000);
      else if (pick < 97)
         clock_ms = clock_ms + $urandom_range(0, 70_000_000);
      else
         clock_ms = clock_ms + $urandom;
   endfunction

   task automatic offer_item(logic [1:0] op, logic [7:0] pins, logic [31:0] tms,
                             logic known, result_type res);
      int gap;
      if ($urandom_range(0, 39) == 0)
         send_quiet = !send_quiet;
      gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_opcode     = op;
      req_pin_levels = pins;
      req_time_ms    = tms;
      cur_known      = known;
      cur_result     = res;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold the sender until every outstanding result has been taken
   task automatic settle_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] wdata);
      settle_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = wdata;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      stim_row_type row;
      int        phase;
      int        issued;
      int        pick;
      int        run;
      int        lvl;
      bit        want;
      logic [7:0] set_mask;
      logic       set_high;
      logic [7:0] set_level;
      logic       set_init;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_SAMPLE;
      req_pin_levels = '0;
      req_time_ms    = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = REG_PIN_MASK;
      csr_wdata      = '0;
      cur_known      = 1'b0;
      cur_result     = '0;
      mismatch_count = 0;
      rsp_hold       = 0;
      send_quiet     = 1'b0;
      recv_quiet     = 1'b0;
      clock_ms       = $urandom;

      // directed: reset values, debounce toggles, saturation, zero and lowered level,
      // active-high mask, time wrap, restart with both initial states
      add_known(OP_TAKE_PRESS,   8'h00, 32'h0000_0000, 1'b0, 1'b0, 16'd0);
      add_known(OP_TAKE_RELEASE, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0);
      add_known(OP_SAMPLE,       8'hFF, 32'h0000_0000, 1'b0, 1'b0, 16'd0);
      add_item(OP_SAMPLE, 8'h00, 32'd1000);
      add_item(OP_SAMPLE, 8'hFE, 32'd2000);
      add_item(OP_SAMPLE, 8'h00, 32'd3000);
      add_known(OP_SAMPLE, 8'h00, 32'd4000, 1'b1, 1'b1, HOLD_MIN);
      add_item(OP_SAMPLE, 8'h00, 32'hFFFF_FFFF);
      add_item(OP_SAMPLE, 8'h00, 32'd5000);
      add_item(OP_TAKE_PRESS, 8'h55, 32'd0);
      add_item(OP_TAKE_PRESS, 8'hAA, 32'd0);
      add_write(REG_TOGGLE_THRESHOLD, 8'd0);
      add_item(OP_SAMPLE, 8'h00, 32'd6000);
      add_item(OP_TAKE_RELEASE, 8'h00, 32'd0);
      add_item(OP_SAMPLE, 8'hFF, 32'd7000);
      add_write(REG_ACTIVE_HIGH, 8'd1);
      add_write(REG_PIN_MASK, 8'hFF);
      add_write(REG_TOGGLE_THRESHOLD, 8'd3);
      add_item(OP_SAMPLE, 8'h7F, 32'd8000);
      add_item(OP_SAMPLE, 8'h00, 32'd9000);
      add_write(REG_TOGGLE_THRESHOLD, 8'd1);
      add_item(OP_SAMPLE, 8'h00, 32'd10000);
      add_item(OP_SAMPLE, 8'hFF, 32'hFFFF_FC18);
      add_item(OP_SAMPLE, 8'hFF, 32'h0000_01F4);
      add_item(OP_SAMPLE, 8'hFF, 32'h0001_0000);
      add_write(REG_INITIAL_ACTIVE, 8'd1);
      add_known(OP_RESTART,      8'h00, 32'h0000_0000, 1'b0, 1'b1, 16'd0);
      add_known(OP_TAKE_PRESS,   8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'd0);
      add_known(OP_TAKE_RELEASE, 8'h0F, 32'h0000_0000, 1'b0, 1'b1, 16'd0);
      add_item(OP_SAMPLE, 8'hFF, 32'd2500);
      add_write(REG_INITIAL_ACTIVE, 8'd0);
      add_known(OP_RESTART, 8'hAA, 32'd1234, 1'b0, 1'b0, 16'd0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE)
            write_reg(row.idx, row.wdata);
         else
            offer_item(row.op, row.pins, row.tms, row.known, row.res);
      end

      // random phases, each under its own register setting
      for (phase = 0; phase < N_PHASES; phase++) begin
         unique case (phase)
            0: begin
               set_mask = 8'hFF; set_high = 1'b0; set_level = 8'd1;   set_init = 1'b1;
            end
            1: begin
               set_mask = 8'h01; set_high = 1'b1; set_level = 8'd255; set_init = 1'b0;
            end
            2: begin
               set_mask = 8'h80; set_high = 1'b0; set_level = 8'd0;   set_init = 1'b0;
            end
            default: begin
               set_mask  = 8'($urandom_range(1, 255));
               set_high  = 1'($urandom_range(0, 1));
               set_level = 8'($urandom_range(0, 12));
               set_init  = 1'($urandom_range(0, 1));
            end
         endcase
         write_reg(REG_PIN_MASK, set_mask);
         write_reg(REG_ACTIVE_HIGH, {7'd0, set_high});
         write_reg(REG_TOGGLE_THRESHOLD, set_level);
         write_reg(REG_INITIAL_ACTIVE, {7'd0, set_init});

         issued = 0;
         while (issued < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // steady run of one level, often just long enough to toggle
               want = 1'($urandom_range(0, 1));
               lvl  = dbc_cfg.toggle_threshold;
               run  = $urandom_range(0, 1) ? lvl + $urandom_range(0, 2)
                                           : $urandom_range(1, lvl + 3);
               if (run == 0)
                  run = 1;
               repeat (run) begin
                  tick_ms();
                  offer_item(OP_SAMPLE, pins_for(want), clock_ms, 1'b0, '0);
                  issued++;
               end
            end else if (pick < 80) begin
               tick_ms();
               offer_item(OP_SAMPLE, 8'($urandom), clock_ms, 1'b0, '0);
               issued++;
            end else if (pick < 88) begin
               offer_item(OP_TAKE_PRESS, 8'($urandom), $urandom, 1'b0, '0);
               issued++;
            end else if (pick < 96) begin
               offer_item(OP_TAKE_RELEASE, 8'($urandom), $urandom, 1'b0, '0);
               issued++;
            end else begin
               tick_ms();
               offer_item(OP_RESTART, 8'($urandom), clock_ms, 1'b0, '0);
               issued++;
            end
            if ($urandom_range(0, 49) == 0)
               settle_results();
         end
      end

      // drain, then let the pipeline run dry
      settle_results();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results still expected", 16'(pending_results.size()), 16'd0);
      if (mismatch_count == 0)
         $display("button_debounce_hold_timer_core verification clean");
      else
         $display("button_debounce_hold_timer_core verification failed");
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("button_debounce_hold_timer_core verification failed");
      $finish;
   end

endmodule

[files.f]
src/bdh_pkg.sv
src/bdh_hold_calc.sv
src/bdh_step.sv
src/button_debounce_hold_timer_core.sv
src/bdh_checker.sv
verif/button_debounce_hold_timer_core_tb.sv
